FILE: design/bsdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsdt_pkg;

	// Longest search or replacement pattern, in bytes (1 to 8)
	localparam int MAX_PATTERN = 8;
	// Width of a byte count that can hold MAX_PATTERN itself
	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	// Width of an index into the pattern bytes
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// Item kinds carried on the mode field
	localparam logic [1:0] MODE_DATA = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_END  = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	// Configuration register indexes; each register sits at byte address 8 * index
	localparam logic [1:0] REG_MATCH_PATTERN   = 2'd0;
	localparam logic [1:0] REG_MATCH_LENGTH    = 2'd1;
	localparam logic [1:0] REG_REPLACE_PATTERN = 2'd2;
	localparam logic [1:0] REG_REPLACE_LENGTH  = 2'd3;

	// Configuration register contents as seen by the datapath
	typedef struct packed {
		logic [63:0] match_pattern;
		logic [3:0]  match_length;
		logic [63:0] replace_pattern;
		logic [3:0]  replace_length;
	} bsdt_cfg_t;

	// One token from the substitution stage to the map stage
	typedef struct packed {
		logic       is_byte;
		logic       is_write;
		logic       fin;
		logic [7:0] data;
		logic [7:0] wr_target;
		logic       wr_delete;
	} bsdt_tok_t;

	// Substitution sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SHIFT,
		ST_REPL
	} bsdt_state_t;

endpackage

`default_nettype wire

FILE: design/bsdt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bsdt_cell (
	input  wire logic       clk,
	input  wire logic       shift,
	input  wire logic       load,
	input  wire logic [7:0] load_byte,
	input  wire logic [7:0] next_byte,
	input  wire logic [7:0] pat_here,
	input  wire logic [7:0] pat_prev,
	input  wire logic       en_here,
	input  wire logic       en_prev,
	output logic      [7:0] cur_byte,
	output logic            miss_here,
	output logic            miss_prev
);

	logic [7:0] byte_q;

	// Take a new byte, or the neighbor's byte on a shift, else hold
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= load_byte;
		end else if (shift) begin
			byte_q <= next_byte;
		end
	end

	// Compare against this position and against the position one lower
	assign miss_here = en_here && (byte_q != pat_here);
	assign miss_prev = en_prev && (byte_q != pat_prev);
	assign cur_byte  = byte_q;

endmodule

`default_nettype wire

FILE: design/bsdt_subst.sv
`timescale 1ns / 1ps
`default_nettype none

module bsdt_subst (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bsdt_pkg::bsdt_cfg_t  cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           mode,
	input  wire logic [7:0]           byte_value,
	input  wire logic [7:0]           map_target,
	input  wire logic                 map_delete,
	output logic                      tok_valid,
	output bsdt_pkg::bsdt_tok_t       tok,
	input  wire logic                 tok_ready
);

	import bsdt_pkg::*;

	bsdt_state_t      state_q, state_d;
	logic [CNT_W-1:0] fill_q, fill_next, fill_m1;
	logic             flush_q, flush_d;
	logic [IDX_W-1:0] rep_idx_q, rep_idx_d;
	logic [1:0]       kind_q;
	logic [7:0]       ld_index_q, ld_target_q;
	logic             ld_delete_q;

	logic [CNT_W-1:0] len, rlen;
	logic [7:0]       win   [MAX_PATTERN];
	logic [7:0]       pat_b [MAX_PATTERN];
	logic [7:0]       rep_b [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] en_here, en_prev, miss_here, miss_prev, load_vec;
	logic             prefix0, prefix1, flush, cont1, shift_first, repl_hit;
	logic             shift_now, repl_start, adv, acc, acc_data;

	// Clamp lengths to the window size
	assign len  = (cfg.match_length > 4'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
		: CNT_W'(cfg.match_length);
	assign rlen = (cfg.replace_length > 4'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
		: CNT_W'(cfg.replace_length);

	// Row of window cells; each shift hands a byte to the lower neighbor
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [7:0] nb, pp;

		assign pat_b[i] = cfg.match_pattern[8*i +: 8];
		assign rep_b[i] = cfg.replace_pattern[8*i +: 8];
		assign en_here[i] = (CNT_W'(i) < fill_q) && (CNT_W'(i) < len);
		assign load_vec[i] = acc_data && (fill_next == CNT_W'(i));

		if (i == 0) begin : g_first
			assign en_prev[i] = 1'b0;
			assign pp = pat_b[0];
		end else begin : g_rest
			assign en_prev[i] = (CNT_W'(i) < fill_q) && (CNT_W'(i - 1) < len);
			assign pp = pat_b[i - 1];
		end

		if (i == MAX_PATTERN - 1) begin : g_top
			assign nb = 8'h00;
		end else begin : g_mid
			assign nb = win[i + 1];
		end

		bsdt_cell u_cell (
			.clk       (clk),
			.shift     (shift_now && adv),
			.load      (load_vec[i]),
			.load_byte (byte_value),
			.next_byte (nb),
			.pat_here  (pat_b[i]),
			.pat_prev  (pp),
			.en_here   (en_here[i]),
			.en_prev   (en_prev[i]),
			.cur_byte  (win[i]),
			.miss_here (miss_here[i]),
			.miss_prev (miss_prev[i])
		);
	end

	// Window decisions on the current window and on the window after one shift
	assign prefix0     = ~|miss_here;
	assign prefix1     = ~|miss_prev;
	assign fill_m1     = fill_q - CNT_W'(1);
	assign flush       = ((state_q == ST_FIRST) && (kind_q == MODE_END))
		|| ((state_q == ST_SHIFT) && flush_q);
	assign cont1       = (fill_m1 != '0) && (flush || (len == '0) || (fill_m1 >= len) || !prefix1);
	assign shift_first = (len == '0) || (fill_q > len) || !prefix0;
	assign repl_hit    = (fill_q == len) && prefix0;

	// Token generation and next state
	always_comb begin
		tok        = '0;
		tok_valid  = 1'b0;
		shift_now  = 1'b0;
		repl_start = 1'b0;
		state_d    = state_q;
		flush_d    = flush_q;
		rep_idx_d  = rep_idx_q;

		unique case (state_q)
			ST_IDLE: begin
			end
			ST_FIRST: begin
				tok_valid = 1'b1;
				unique case (kind_q)
					MODE_DATA: begin
						if (shift_first) begin
							tok.is_byte = 1'b1;
							tok.data    = win[0];
							tok.fin     = !cont1;
							shift_now   = 1'b1;
							state_d     = ST_SHIFT;
							flush_d     = 1'b0;
						end else if (repl_hit) begin
							repl_start = 1'b1;
							if (rlen == '0) begin
								tok.fin = 1'b1;
							end else begin
								tok.is_byte = 1'b1;
								tok.data    = rep_b[0];
								tok.fin     = (rlen == CNT_W'(1));
								state_d     = ST_REPL;
								rep_idx_d   = IDX_W'(1);
							end
						end else begin
							tok.fin = 1'b1;
						end
					end
					MODE_LOAD: begin
						tok.is_write  = 1'b1;
						tok.data      = ld_index_q;
						tok.wr_target = ld_target_q;
						tok.wr_delete = ld_delete_q;
						tok.fin       = 1'b1;
					end
					MODE_END: begin
						if (fill_q != '0) begin
							tok.is_byte = 1'b1;
							tok.data    = win[0];
							tok.fin     = !cont1;
							shift_now   = 1'b1;
							state_d     = ST_SHIFT;
							flush_d     = 1'b1;
						end else begin
							tok.fin = 1'b1;
						end
					end
					default: begin
						tok.fin = 1'b1;
					end
				endcase
			end
			ST_SHIFT: begin
				tok_valid   = 1'b1;
				tok.is_byte = 1'b1;
				tok.data    = win[0];
				tok.fin     = !cont1;
				shift_now   = 1'b1;
			end
			ST_REPL: begin
				tok_valid   = 1'b1;
				tok.is_byte = 1'b1;
				tok.data    = rep_b[rep_idx_q];
				tok.fin     = ((CNT_W'(rep_idx_q) + CNT_W'(1)) == rlen);
				rep_idx_d   = rep_idx_q + IDX_W'(1);
			end
			default: begin
			end
		endcase

		adv      = tok_valid && tok_ready;
		in_ready = (state_q == ST_IDLE) || (tok_ready && tok.fin);
		acc      = in_valid && in_ready;
		acc_data = acc && (mode == MODE_DATA);

		// Hold everything while the token waits
		if (!adv) begin
			state_d   = state_q;
			flush_d   = flush_q;
			rep_idx_d = rep_idx_q;
		end else if (tok.fin) begin
			state_d = ST_IDLE;
		end
		if (acc) begin
			state_d = ST_FIRST;
		end

		// Fill after this cycle's action, before a new byte is appended
		if (adv && shift_now) begin
			fill_next = fill_m1;
		end else if (adv && repl_start) begin
			fill_next = '0;
		end else begin
			fill_next = fill_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			flush_q   <= 1'b0;
			rep_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			flush_q   <= flush_d;
			rep_idx_q <= rep_idx_d;
			fill_q    <= acc_data ? (fill_next + CNT_W'(1)) : fill_next;
		end
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q      <= mode;
			ld_index_q  <= byte_value;
			ld_target_q <= map_target;
			ld_delete_q <= map_delete;
		end
	end

`ifndef SYNTHESIS
	a_idle_fill : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q < CNT_W'(MAX_PATTERN)))
		else $error("window overfull while idle");
	a_repl_empty : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPL) |-> (fill_q == '0))
		else $error("window not cleared during replacement");
	a_shift_fill : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (fill_q != '0))
		else $error("shift with empty window");
	a_in_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && !tok_ready) |-> !in_ready)
		else $error("input taken while token stalled");
`endif

endmodule

`default_nettype wire

FILE: design/bsdt_map.sv
`timescale 1ns / 1ps
`default_nettype none

module bsdt_map (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tok_valid,
	input  wire bsdt_pkg::bsdt_tok_t  tok,
	output logic                      tok_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                out_byte,
	output logic                      has_byte,
	output logic                      last
);

	import bsdt_pkg::*;

	logic [8:0]   map_mem [256];
	logic [255:0] map_vld_q;

	logic       tok_v_s1, is_byte_s1, fin_s1, hit_s1;
	logic [7:0] data_s1;
	logic [8:0] rd_s1;

	logic       hold_v_q, hold_fin_q;
	logic [7:0] hold_byte_q;

	logic       out_valid_q, has_byte_q, last_q;
	logic [7:0] out_byte_q;

	logic       tok_acc, out_free, survive;
	logic [7:0] ent_target;
	logic       emit, e_has, e_last, s1_take, hold_load, hold_clr;
	logic [7:0] e_byte;

	assign tok_acc = tok_valid && tok_ready;

	// Map memory: write on load tokens, registered read for byte tokens
	always_ff @(posedge clk) begin
		if (tok_acc && tok.is_write) begin
			map_mem[tok.data] <= {tok.wr_delete, tok.wr_target};
		end
		if (tok_acc && tok.is_byte) begin
			rd_s1  <= map_mem[tok.data];
			hit_s1 <= map_vld_q[tok.data];
		end
		if (tok_acc) begin
			is_byte_s1 <= tok.is_byte;
			fin_s1     <= tok.fin;
			data_s1    <= tok.data;
		end
	end

	// Entries never loaded read as identity, no deletion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q <= '0;
		end else if (tok_acc && tok.is_write) begin
			map_vld_q[tok.data] <= 1'b1;
		end
	end

	assign ent_target = hit_s1 ? rd_s1[7:0] : data_s1;
	assign survive    = is_byte_s1 && !(hit_s1 && rd_s1[8]);
	assign out_free   = !out_valid_q || out_ready;

	// Keep one surviving byte back so the final one can carry last
	always_comb begin
		emit      = 1'b0;
		e_byte    = 8'h00;
		e_has     = 1'b0;
		e_last    = 1'b0;
		s1_take   = 1'b0;
		hold_load = 1'b0;
		hold_clr  = 1'b0;
		if (hold_v_q && hold_fin_q) begin
			e_byte = hold_byte_q;
			e_has  = 1'b1;
			e_last = 1'b1;
			if (out_free) begin
				emit     = 1'b1;
				hold_clr = 1'b1;
			end
		end else if (tok_v_s1) begin
			if (survive) begin
				if (hold_v_q) begin
					e_byte = hold_byte_q;
					e_has  = 1'b1;
					if (out_free) begin
						emit      = 1'b1;
						s1_take   = 1'b1;
						hold_load = 1'b1;
					end
				end else if (fin_s1) begin
					e_byte = ent_target;
					e_has  = 1'b1;
					e_last = 1'b1;
					if (out_free) begin
						emit    = 1'b1;
						s1_take = 1'b1;
					end
				end else begin
					s1_take   = 1'b1;
					hold_load = 1'b1;
				end
			end else if (fin_s1) begin
				e_byte = hold_v_q ? hold_byte_q : 8'h00;
				e_has  = hold_v_q;
				e_last = 1'b1;
				if (out_free) begin
					emit     = 1'b1;
					s1_take  = 1'b1;
					hold_clr = 1'b1;
				end
			end else begin
				s1_take = 1'b1;
			end
		end
	end

	assign tok_ready = !tok_v_s1 || s1_take;

	// Stage valid, hold valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_s1    <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_ready) begin
				tok_v_s1 <= tok_valid;
			end
			if (hold_load) begin
				hold_v_q <= 1'b1;
			end else if (hold_clr) begin
				hold_v_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Held byte and output payload
	always_ff @(posedge clk) begin
		if (hold_load) begin
			hold_byte_q <= ent_target;
			hold_fin_q  <= fin_s1;
		end
		if (emit) begin
			out_byte_q <= e_byte;
			has_byte_q <= e_has;
			last_q     <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_byte_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_empty_last : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !has_byte_q) |-> last_q)
		else $error("empty result without last");
	a_hold_first : assert property (@(posedge clk) disable iff (!arst_n)
		(hold_v_q && hold_fin_q) |-> !s1_take)
		else $error("stage consumed while final byte is held");
	a_hold_drain : assert property (@(posedge clk) disable iff (!arst_n)
		(hold_v_q && hold_fin_q && out_free) |=> !(hold_v_q && hold_fin_q))
		else $error("final held byte not released");
`endif

endmodule

`default_nettype wire

FILE: design/byte_substitute_delete_translate.sv
`timescale 1ns / 1ps
`default_nettype none

// Latency: a first result passes the sequencer state, the map stage and output register;
// an item that makes several tokens also waits in the held byte. Throughput: one input
// per cycle without output back-pressure when each item leaves at most one byte; an item
// that shifts out or replaces n bytes holds the input while the window row delivers them
// one byte a cycle unstalled, plus the drain of the held byte when two or more survive.
// Reset: asynchronous, active low; clears control/config registers to zero, empties the
// window fill; map: identity, no deletions (per-entry valid bits, no clearing pass).

module byte_substitute_delete_translate (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  byte_value,
	input  wire logic [7:0]  map_target,
	input  wire logic        map_delete,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  out_byte,
	output logic             has_byte,
	output logic             last
);

	import bsdt_pkg::*;

	bsdt_cfg_t  cfg_q;
	bsdt_tok_t  tok;
	logic       tok_valid, tok_ready, cfg_wr;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write configuration registers in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MATCH_PATTERN:   cfg_q.match_pattern   <= pwdata;
				REG_MATCH_LENGTH:    cfg_q.match_length    <= pwdata[3:0];
				REG_REPLACE_PATTERN: cfg_q.replace_pattern <= pwdata;
				REG_REPLACE_LENGTH:  cfg_q.replace_length  <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_sel)
			REG_MATCH_PATTERN:   prdata = cfg_q.match_pattern;
			REG_MATCH_LENGTH:    prdata = {60'd0, cfg_q.match_length};
			REG_REPLACE_PATTERN: prdata = cfg_q.replace_pattern;
			REG_REPLACE_LENGTH:  prdata = {60'd0, cfg_q.replace_length};
			default:             prdata = '0;
		endcase
	end

	bsdt_subst u_subst (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.byte_value (byte_value),
		.map_target (map_target),
		.map_delete (map_delete),
		.tok_valid  (tok_valid),
		.tok        (tok),
		.tok_ready  (tok_ready)
	);

	bsdt_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_ready (tok_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.last      (last)
	);

endmodule

`default_nettype wire
